// ===== rtl/core/cbsf_pkg.sv =====
`timescale 1ns / 1ps

package cbsf_pkg;

    // framing constants
    localparam logic [7:0]  FLAG_BYTE  = 8'h7E;
    localparam logic [7:0]  ESC_BYTE   = 8'h7D;
    localparam logic [7:0]  ESC_XOR    = 8'h20;
    localparam logic [15:0] CRC_POLY   = 16'h1021;

    // queue between front and back
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // one classified message byte with the CRC value after it
    typedef struct packed {
        logic [7:0]  msg_byte;
        logic        first;
        logic        last;
        logic [15:0] crc;
    } t_entry;

    // emitter phases
    typedef enum logic [2:0] {
        PH_IDLE,
        PH_OPEN,
        PH_DATA,
        PH_CRC_LO,
        PH_CRC_HI,
        PH_CLOSE
    } t_phase;

    // CRC-16, poly 0x1021, MSB first, one byte
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// ===== rtl/core/cbsf_front.sv =====
`timescale 1ns / 1ps

module cbsf_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    input  logic [7:0]        i_s_axis_tdata,   // [7:0] msg_byte
    input  logic              i_s_axis_tuser,   // [0] first_of_message
    input  logic              i_s_axis_tlast,   // last_of_message
    input  logic              i_full,
    output logic              o_push,
    output cbsf_pkg::t_entry  o_ent
);
    import cbsf_pkg::*;

    logic [15:0] r_crc;
    logic [15:0] n_crc;
    logic [15:0] crc_base;
    logic [15:0] crc_new;

    // accept whenever the queue has room
    assign o_s_axis_tready = !i_full;
    assign o_push          = i_s_axis_tvalid && !i_full;

    // fold the byte into the running CRC
    assign crc_base = i_s_axis_tuser ? 16'h0000 : r_crc;
    assign crc_new  = crc16_byte(crc_base, i_s_axis_tdata);

    always_comb begin
        n_crc = r_crc;
        if (o_push) begin
            n_crc = i_s_axis_tlast ? 16'h0000 : crc_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc <= 16'h0000;
        end else begin
            r_crc <= n_crc;
        end
    end

    // classified entry for the back end
    assign o_ent.msg_byte = i_s_axis_tdata;
    assign o_ent.first    = i_s_axis_tuser;
    assign o_ent.last     = i_s_axis_tlast;
    assign o_ent.crc      = crc_new;

    // CRC restarts from zero after a message end
    a_crc_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && i_s_axis_tlast) |=> (r_crc == 16'h0000))
        else $error("CRC not cleared after message end");

endmodule

// ===== rtl/core/cbsf_queue.sv =====
`timescale 1ns / 1ps

module cbsf_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  cbsf_pkg::t_entry  i_ent,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_empty,
    output cbsf_pkg::t_entry  o_head
);
    import cbsf_pkg::*;

    t_entry              r_mem [QDEPTH];
    logic [QPTR_W-1:0]   r_wr_ptr;
    logic [QPTR_W-1:0]   r_rd_ptr;
    logic [QCNT_W-1:0]   r_count;
    logic [QPTR_W-1:0]   n_wr_ptr;
    logic [QPTR_W-1:0]   n_rd_ptr;
    logic [QCNT_W-1:0]   n_count;

    assign o_full  = (r_count == QCNT_W'(QDEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];

    // pointer and count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_ent;
        end
    end

    // occupancy stays within depth
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCNT_W'(QDEPTH))
        else $error("queue overflow");

endmodule

// ===== rtl/core/cbsf_back.sv =====
`timescale 1ns / 1ps

module cbsf_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_empty,
    input  cbsf_pkg::t_entry  i_head,
    output logic              o_pop,
    output logic              o_m_axis_tvalid,
    input  logic              i_m_axis_tready,
    output logic [7:0]        o_m_axis_tdata,
    output logic              o_m_axis_tlast,
    output logic              o_m_axis_tuser
);
    import cbsf_pkg::*;

    t_phase      r_phase;
    t_phase      n_phase;
    logic        r_esc;
    logic        n_esc;
    t_entry      r_ent;
    logic        r_ovalid;
    logic        n_ovalid;
    logic [7:0]  r_obyte;
    logic        r_olast;
    logic        r_oend;

    logic        emit;
    logic        load;
    logic [7:0]  val;
    logic        special;
    logic        need_second;
    logic        final_beat;
    logic [7:0]  cur_byte;
    logic        cur_end;

    // value carried by the current phase
    always_comb begin
        case (r_phase)
            PH_DATA:   val = r_ent.msg_byte;
            PH_CRC_LO: val = r_ent.crc[7:0];
            PH_CRC_HI: val = r_ent.crc[15:8];
            default:   val = FLAG_BYTE;
        endcase
    end

    assign special     = val inside {FLAG_BYTE, ESC_BYTE};
    assign need_second = !r_esc && special
                         && (r_phase == PH_DATA || r_phase == PH_CRC_LO
                             || r_phase == PH_CRC_HI);
    assign final_beat  = (r_phase == PH_CLOSE)
                         || (r_phase == PH_DATA && !r_ent.last && !need_second);

    // a beat goes out when the output register is free or drains
    assign emit  = (r_phase != PH_IDLE) && (!r_ovalid || i_m_axis_tready);
    assign load  = ((r_phase == PH_IDLE) || (emit && final_beat)) && !i_empty;
    assign o_pop = load;

    // next state
    always_comb begin
        n_phase = r_phase;
        n_esc   = r_esc;
        if (emit) begin
            if (need_second) begin
                n_esc = 1'b1;
            end else begin
                n_esc = 1'b0;
                case (r_phase)
                    PH_OPEN:   n_phase = PH_DATA;
                    PH_DATA:   n_phase = r_ent.last ? PH_CRC_LO : PH_IDLE;
                    PH_CRC_LO: n_phase = PH_CRC_HI;
                    PH_CRC_HI: n_phase = PH_CLOSE;
                    PH_CLOSE:  n_phase = PH_IDLE;
                    default:   n_phase = PH_IDLE;
                endcase
            end
        end
        if (load) begin
            n_phase = i_head.first ? PH_OPEN : PH_DATA;
            n_esc   = 1'b0;
        end
    end

    // beat contents
    always_comb begin
        cur_end = 1'b0;
        case (r_phase)
            PH_OPEN: begin
                cur_byte = FLAG_BYTE;
            end
            PH_CLOSE: begin
                cur_byte = FLAG_BYTE;
                cur_end  = 1'b1;
            end
            PH_DATA, PH_CRC_LO, PH_CRC_HI: begin
                if (r_esc) begin
                    cur_byte = val ^ ESC_XOR;
                end else if (special) begin
                    cur_byte = ESC_BYTE;
                end else begin
                    cur_byte = val;
                end
            end
            default: begin
                cur_byte = FLAG_BYTE;
            end
        endcase
    end

    always_comb begin
        n_ovalid = r_ovalid;
        if (emit) begin
            n_ovalid = 1'b1;
        end else if (i_m_axis_tready) begin
            n_ovalid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_esc    <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_phase  <= n_phase;
            r_esc    <= n_esc;
            r_ovalid <= n_ovalid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_ent <= i_head;
        end
        if (emit) begin
            r_obyte <= cur_byte;
            r_olast <= final_beat;
            r_oend  <= cur_end;
        end
    end

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = r_obyte;
    assign o_m_axis_tlast  = r_olast;
    assign o_m_axis_tuser  = r_oend;

    // closing flag is a 0x7E and ends the run
    a_close_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_oend) |-> (r_obyte == FLAG_BYTE && r_olast))
        else $error("bad closing flag beat");

    // an escape prefix is always followed by its byte
    a_esc_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_obyte == ESC_BYTE) |-> !r_olast)
        else $error("escape prefix ends a run");

endmodule

// ===== rtl/core/crc16_byte_stuffed_framer_unit.sv =====
`timescale 1ns / 1ps
// Channel   Dir  tdata            tuser             tlast
// s_axis    in   [7:0] msg_byte   [0] first_of_msg  last_of_message
// m_axis    out  [7:0] out_byte   [0] frame_end     last_of_run
//
// The back end sends one output beat per cycle while m_axis accepts and the queue
// holds entries; an input beat causes 1 to 8 output beats (flag, escapes, CRC
// bytes, closing flag). A plain unmarked byte yields a single beat.
// The front computes the CRC in the accept cycle and queues 4 entries deep.
// Reset is synchronous, active low, with no clearing pass.
// Output stalls fill the queue, then drop s_axis tready.

module crc16_byte_stuffed_framer_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] msg_byte
    input  logic        i_s_axis_tuser,   // [0] first_of_message
    input  logic        i_s_axis_tlast,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata,   // [7:0] out_byte
    output logic        o_m_axis_tuser,   // [0] frame_end
    output logic        o_m_axis_tlast
);
    import cbsf_pkg::*;

    logic    push;
    logic    pop;
    logic    full;
    logic    empty;
    t_entry  ent_in;
    t_entry  ent_head;

    cbsf_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .i_full          (full),
        .o_push          (push),
        .o_ent           (ent_in)
    );

    cbsf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_ent   (ent_in),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_head  (ent_head)
    );

    cbsf_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_empty         (empty),
        .i_head          (ent_head),
        .o_pop           (pop),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

endmodule
